>>> rtl/mmcs_pkg.sv
package mmcs_pkg;

	localparam int REG_BYTES = 16;
	localparam int REG_IDX_W = $clog2(REG_BYTES);
	localparam int CSD_W = REG_BYTES * 8;

	typedef enum logic [14:0] {
		ST_IDLE    = 15'b000000000000001,
		ST_PRE     = 15'b000000000000010,
		ST_FRAME   = 15'b000000000000100,
		ST_POLL    = 15'b000000000001000,
		ST_EXTRA   = 15'b000000000010000,
		ST_TOKEN   = 15'b000000000100000,
		ST_READ    = 15'b000000001000000,
		ST_CONFIRM = 15'b000000010000000,
		ST_BUSY1   = 15'b000000100000000,
		ST_DATA    = 15'b000001000000000,
		ST_DRESP   = 15'b000010000000000,
		ST_BUSY2   = 15'b000100000000000,
		ST_DONE    = 15'b001000000000000,
		ST_ABORT0  = 15'b010000000000000,
		ST_ABORT1  = 15'b100000000000000
	} stage_t;

	localparam logic [1:0] MODE_START   = 2'd0;
	localparam logic [1:0] MODE_BYTE    = 2'd1;
	localparam logic [1:0] MODE_CONFIRM = 2'd2;

	localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
	localparam logic [5:0] CMD_SEND_OP   = 6'd1;
	localparam logic [5:0] CMD_SEND_CSD  = 6'd9;
	localparam logic [5:0] CMD_SEND_CID  = 6'd10;
	localparam logic [5:0] CMD_STATUS    = 6'd13;
	localparam logic [5:0] CMD_BLOCKLEN  = 6'd16;
	localparam logic [5:0] CMD_LOCK      = 6'd42;

	localparam logic [2:0] STAT_RUN     = 3'd0;
	localparam logic [2:0] STAT_CONFIRM = 3'd1;
	localparam logic [2:0] STAT_DONE    = 3'd2;
	localparam logic [2:0] STAT_ABORT0  = 3'd3;
	localparam logic [2:0] STAT_ABORT1  = 3'd4;

	localparam logic [1:0] CFG_RETRY_LIMIT = 2'd0;
	localparam logic [1:0] CFG_NCR_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_PREAMBLE    = 2'd2;

	localparam logic [7:0] BYTE_IDLE     = 8'hFF;
	localparam logic [7:0] BYTE_TOKEN    = 8'hFE;
	localparam logic [7:0] BYTE_CMD_BASE = 8'h40;
	localparam logic [7:0] BYTE_CRC      = 8'h95;
	localparam logic [7:0] BYTE_FORCE    = 8'b00001000;
	localparam logic [7:0] DRESP_MASK    = 8'b00011111;

	typedef struct packed {
		logic [7:0] retry_limit;
		logic [3:0] ncr_limit;
		logic [7:0] preamble_count;
	} cfg_t;

	typedef struct packed {
		logic                 we;
		logic [REG_IDX_W-1:0] idx;
		logic [7:0]           data;
	} csd_wr_t;

	typedef struct packed {
		logic [4:0]  erase_response;
		logic [3:0]  block_len_log2;
		logic [21:0] card_blocks;
		logic [7:0]  last_response;
		logic [2:0]  status;
		logic        select_low;
		logic        transfer_request;
		logic [7:0]  tx_byte;
	} result_t;

	// forced-erase data packet: token, erase flag, two filler bytes
	function automatic logic [7:0] data_packet(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = BYTE_TOKEN;
			2'd1: b = BYTE_FORCE;
			default: b = BYTE_IDLE;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/mmc_spi_init_and_erase_sequencer.sv
// Byte-level SPI master script for bringing an MMC card up in SPI mode: preamble, CMD0 and CMD1
// with retry limits, CMD13, CSD read (block count and length decoded), CID read, then after a
// confirm item, CMD16 and a forced-erase CMD42. Each input transfer (start, received byte or
// confirm) yields exactly one result transfer holding the next byte to send, whether to send it,
// the select level and status. One item is taken per clock: the sequencer state updates in the
// cycle of the input transfer and the result sits in a single output register, so throughput is
// one item per cycle as long as the result side keeps taking.
// Configuration writes must happen while no result is pending.
module mmc_spi_init_and_erase_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // rx_byte
	input  logic [1:0]  s_axis_tuser,   // mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tx_byte, transfer_request, select_low, status, last_response, card_blocks,
	// block_len_log2, erase_response, zero fill
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import mmcs_pkg::*;

	cfg_t        cfg_q;
	csd_wr_t     csd_wr;
	result_t     result;
	result_t     out_q;
	logic        out_valid_q;
	logic        take;
	logic [21:0] csd_blocks;
	logic [3:0]  csd_len;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign take = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.retry_limit    <= 8'd255;
			cfg_q.ncr_limit      <= 4'd8;
			cfg_q.preamble_count <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RETRY_LIMIT: cfg_q.retry_limit <= cfg_data;
				CFG_NCR_LIMIT:   cfg_q.ncr_limit <= cfg_data[3:0];
				CFG_PREAMBLE:    cfg_q.preamble_count <= cfg_data;
				default: ;
			endcase
		end
	end

	mmcs_csd u_csd (
		.clk            (clk),
		.wr             (csd_wr),
		.card_blocks    (csd_blocks),
		.block_len_log2 (csd_len)
	);

	mmcs_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.mode       (s_axis_tuser),
		.rx_byte    (s_axis_tdata),
		.cfg        (cfg_q),
		.csd_blocks (csd_blocks),
		.csd_len    (csd_len),
		.csd_wr     (csd_wr),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q};

endmodule

>>> rtl/mmcs_csd.sv
module mmcs_csd (
	input  logic               clk,
	input  mmcs_pkg::csd_wr_t  wr,
	output logic [21:0]        card_blocks,
	output logic [3:0]         block_len_log2
);
	import mmcs_pkg::*;

	logic [7:0]       mem [REG_BYTES];
	logic [CSD_W-1:0] csd_vec;
	logic [11:0]      c_size;
	logic [2:0]       c_mult;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.idx] <= wr.data;
		end
	end

	for (genvar i = 0; i < REG_BYTES; i++) begin : g_flat
		assign csd_vec[i*8 +: 8] = mem[i];
	end

	assign c_size = csd_vec[73:62];
	assign c_mult = csd_vec[49:47];
	assign block_len_log2 = csd_vec[83:80];
	assign card_blocks = ({10'd0, c_size} + 22'd1) << ({1'b0, c_mult} + 4'd2);

endmodule

>>> rtl/mmcs_seq.sv
module mmcs_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [1:0]        mode,
	input  logic [7:0]        rx_byte,
	input  mmcs_pkg::cfg_t    cfg,
	input  logic [21:0]       csd_blocks,
	input  logic [3:0]        csd_len,
	output mmcs_pkg::csd_wr_t csd_wr,
	output mmcs_pkg::result_t result
);
	import mmcs_pkg::*;

	stage_t      stage_q, stage_d;
	logic [7:0]  bidx_q, bidx_d;
	logic [7:0]  retry_q, retry_d;
	logic [3:0]  poll_q, poll_d;
	logic [5:0]  cmd_q, cmd_d;
	logic [7:0]  resp_q, resp_d;
	logic [21:0] blocks_q, blocks_d;
	logic [3:0]  len_q, len_d;
	logic [4:0]  erase_q, erase_d;
	logic [7:0]  bidx_inc;
	logic [3:0]  poll_inc;

	assign bidx_inc = bidx_q + 8'd1;
	assign poll_inc = poll_q + 4'd1;

	always_comb begin
		stage_d  = stage_q;
		bidx_d   = bidx_q;
		retry_d  = retry_q;
		poll_d   = poll_q;
		cmd_d    = cmd_q;
		resp_d   = resp_q;
		blocks_d = blocks_q;
		len_d    = len_q;
		erase_d  = erase_q;
		csd_wr.we   = 1'b0;
		csd_wr.idx  = REG_IDX_W'(REG_BYTES - 1) - bidx_q[REG_IDX_W-1:0];
		csd_wr.data = rx_byte;
		if (mode == MODE_START) begin
			stage_d  = ST_PRE;
			bidx_d   = '0;
			retry_d  = '0;
			poll_d   = '0;
			cmd_d    = CMD_GO_IDLE;
			resp_d   = '0;
			blocks_d = '0;
			len_d    = '0;
			erase_d  = '0;
		end else if (mode == MODE_CONFIRM) begin
			if (stage_q == ST_CONFIRM) begin
				cmd_d = CMD_BLOCKLEN; stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
			end
		end else if (mode == MODE_BYTE) begin
			case (stage_q)
				ST_PRE: begin
					bidx_d = bidx_inc;
					if (bidx_inc >= cfg.preamble_count) begin
						cmd_d = CMD_GO_IDLE; stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
					end
				end
				ST_FRAME: begin
					bidx_d = bidx_inc;
					if (bidx_inc >= 8'd7) begin
						stage_d = ST_POLL; poll_d = '0;
					end
				end
				ST_POLL: begin
					poll_d = poll_inc;
					if (rx_byte != BYTE_IDLE || poll_inc >= cfg.ncr_limit || poll_inc == 4'd0) begin
						resp_d = rx_byte;
						case (cmd_q)
							CMD_GO_IDLE: begin
								if (rx_byte != 8'd0) begin
									retry_d = '0;
									cmd_d = CMD_SEND_OP; stage_d = ST_FRAME;
									bidx_d = '0; poll_d = '0;
								end else if (retry_q >= cfg.retry_limit) begin
									stage_d = ST_ABORT0;
								end else begin
									retry_d = retry_q + 8'd1;
									stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
								end
							end
							CMD_SEND_OP: begin
								if (rx_byte == 8'd0) begin
									cmd_d = CMD_STATUS; stage_d = ST_FRAME;
									bidx_d = '0; poll_d = '0;
								end else if (retry_q >= cfg.retry_limit) begin
									stage_d = ST_ABORT1;
								end else begin
									retry_d = retry_q + 8'd1;
									stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
								end
							end
							CMD_STATUS: stage_d = ST_EXTRA;
							CMD_SEND_CSD, CMD_SEND_CID: begin
								stage_d = ST_TOKEN; bidx_d = '0;
							end
							CMD_BLOCKLEN: begin
								cmd_d = CMD_LOCK; stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
							end
							CMD_LOCK: stage_d = ST_BUSY1;
							default: stage_d = ST_IDLE;
						endcase
					end
				end
				ST_EXTRA: begin
					cmd_d = CMD_SEND_CSD; stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
				end
				ST_TOKEN: begin
					if (rx_byte == BYTE_TOKEN) begin
						stage_d = ST_READ; bidx_d = '0;
					end
				end
				ST_READ: begin
					csd_wr.we = take && (cmd_q == CMD_SEND_CSD) && (bidx_q < 8'(REG_BYTES));
					bidx_d = bidx_inc;
					if (bidx_inc >= 8'(REG_BYTES)) begin
						if (cmd_q == CMD_SEND_CSD) begin
							// fields lie above byte 0, so the stored bytes are complete here
							len_d = csd_len;
							blocks_d = csd_blocks;
							cmd_d = CMD_SEND_CID; stage_d = ST_FRAME; bidx_d = '0; poll_d = '0;
						end else begin
							stage_d = ST_CONFIRM;
						end
					end
				end
				ST_BUSY1: begin
					if (rx_byte != 8'd0) begin
						stage_d = ST_DATA; bidx_d = '0;
					end
				end
				ST_DATA: begin
					bidx_d = bidx_inc;
					if (bidx_inc >= 8'd4) stage_d = ST_DRESP;
				end
				ST_DRESP: begin
					erase_d = 5'(rx_byte & DRESP_MASK);
					stage_d = ST_BUSY2;
				end
				ST_BUSY2: begin
					if (rx_byte != 8'd0) stage_d = ST_DONE;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q  <= ST_IDLE;
			bidx_q   <= '0;
			retry_q  <= '0;
			poll_q   <= '0;
			cmd_q    <= '0;
			resp_q   <= '0;
			blocks_q <= '0;
			len_q    <= '0;
			erase_q  <= '0;
		end else if (take) begin
			stage_q  <= stage_d;
			bidx_q   <= bidx_d;
			retry_q  <= retry_d;
			poll_q   <= poll_d;
			cmd_q    <= cmd_d;
			resp_q   <= resp_d;
			blocks_q <= blocks_d;
			len_q    <= len_d;
			erase_q  <= erase_d;
		end
	end

	// result reflects the state after this transfer
	always_comb begin
		result.tx_byte          = BYTE_IDLE;
		result.transfer_request = 1'b1;
		result.select_low       = 1'b1;
		result.status           = STAT_RUN;
		result.last_response    = resp_d;
		result.card_blocks      = blocks_d;
		result.block_len_log2   = len_d;
		result.erase_response   = erase_d;
		case (stage_d)
			ST_IDLE: begin
				result.transfer_request = 1'b0;
				result.select_low = 1'b0;
			end
			ST_PRE: result.select_low = 1'b0;
			ST_FRAME: begin
				case (bidx_d)
					8'd1: result.tx_byte = BYTE_CMD_BASE | {2'b00, cmd_d};
					8'd2, 8'd3, 8'd4: result.tx_byte = 8'd0;
					8'd5: result.tx_byte = (cmd_d == CMD_BLOCKLEN) ? 8'd1 : 8'd0;
					8'd6: result.tx_byte = BYTE_CRC;
					default: result.tx_byte = BYTE_IDLE;
				endcase
			end
			ST_DATA: result.tx_byte = data_packet(bidx_d[1:0]);
			ST_CONFIRM: begin
				result.transfer_request = 1'b0;
				result.status = STAT_CONFIRM;
			end
			ST_DONE: begin
				result.transfer_request = 1'b0;
				result.status = STAT_DONE;
			end
			ST_ABORT0: begin
				result.transfer_request = 1'b0;
				result.status = STAT_ABORT0;
			end
			ST_ABORT1: begin
				result.transfer_request = 1'b0;
				result.status = STAT_ABORT1;
			end
			default: ;
		endcase
	end

endmodule
